// ----- hdl/lrps_pkg.sv -----
package lrps_pkg;

  localparam int NUM_STATES  = 256;
  localparam int NUM_SYMBOLS = 64;
  localparam int NUM_RULES   = 256;
  localparam int STACK_DEPTH = 64;
  localparam int MAX_RHS     = 15;

  localparam int OP_W     = 2;
  localparam int LEX_W    = 2;
  localparam int STATE_W  = 8;
  localparam int SYM_W    = 6;
  localparam int KIND_W   = 2;
  localparam int RULE_W   = 8;
  localparam int LEN_W    = 4;
  localparam int STATUS_W = 2;
  localparam int ACT_W    = 2;

  localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
  localparam int STK_AW  = $clog2(STACK_DEPTH);
  localparam int ROW_AW  = $clog2(NUM_STATES);
  localparam int SYM_AW  = $clog2(NUM_SYMBOLS);
  localparam int CELL_W  = ROW_AW + SYM_AW;
  localparam int CELLS   = 1 << CELL_W;
  localparam int RULE_AW = $clog2(NUM_RULES);

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [SYM_W-1:0] END_TOKEN = SYM_W'(63);

  localparam logic [PADDR_W-3:0] REG_START_STATE = '0;

  localparam logic [OP_W-1:0] OP_PARSE     = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_ACT  = 2'd1;
  localparam logic [OP_W-1:0] OP_LOAD_GOTO = 2'd2;
  localparam logic [OP_W-1:0] OP_LOAD_RULE = 2'd3;

  localparam logic [LEX_W-1:0] LEX_OK  = 2'd0;
  localparam logic [LEX_W-1:0] LEX_END = 2'd1;

  localparam logic [KIND_W-1:0] KIND_SHIFT  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REDUCE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ACCEPT = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FINISH = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ERROR  = 2'd2;

  localparam logic [ACT_W-1:0] ACT_SHIFT  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_REDUCE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_ACCEPT = 2'd2;
  localparam logic [ACT_W-1:0] ACT_NONE   = 2'd3;

  typedef struct packed {
    logic              vld;
    logic [KIND_W-1:0] kind;
    logic [STATE_W-1:0] val;
  } act_entry_t;

  typedef struct packed {
    logic               vld;
    logic [STATE_W-1:0] val;
  } goto_entry_t;

  typedef struct packed {
    logic [SYM_W-1:0] lhs;
    logic [LEN_W-1:0] len;
  } rule_entry_t;

  typedef struct packed {
    logic               act_re;
    logic [CELL_W-1:0]  act_raddr;
    logic               goto_re;
    logic [CELL_W-1:0]  goto_raddr;
    logic               rule_re;
    logic [RULE_AW-1:0] rule_raddr;
    logic               act_we;
    logic               goto_we;
    logic               rule_we;
    logic [CELL_W-1:0]  ld_cell;
    act_entry_t         ld_act;
    goto_entry_t        ld_goto;
    logic [RULE_AW-1:0] ld_rule_idx;
    rule_entry_t        ld_rule;
  } tbl_req_t;

  typedef struct packed {
    logic        busy;
    act_entry_t  act;
    goto_entry_t goto_e;
    rule_entry_t rule;
    logic        rule_vld;
  } tbl_rsp_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ACT_W-1:0]    action_taken;
    logic                consume_token;
    logic [STATE_W-1:0]  pushed_state;
    logic [RULE_W-1:0]   reduced_rule;
    logic [SYM_W-1:0]    reduced_lhs;
    logic [LEN_W-1:0]    reduced_length;
    logic [DEPTH_W-1:0]  stack_depth;
  } res_t;

  function automatic logic [CELL_W-1:0] cell_addr(logic [STATE_W-1:0] s,
                                                  logic [SYM_W-1:0] y);
    return {ROW_AW'(s), SYM_AW'(y)};
  endfunction

endpackage

// ----- hdl/lrps_item_if.sv -----
interface lrps_item_if;
  logic                           valid;
  logic                           ready;
  logic [lrps_pkg::OP_W-1:0]      operation;
  logic [lrps_pkg::LEX_W-1:0]     lexer_status;
  logic [lrps_pkg::SYM_W-1:0]     token_id;
  logic [lrps_pkg::STATE_W-1:0]   table_row;
  logic [lrps_pkg::SYM_W-1:0]     table_symbol;
  logic [lrps_pkg::KIND_W-1:0]    entry_kind;
  logic [lrps_pkg::STATE_W-1:0]   entry_value;
  logic [lrps_pkg::RULE_W-1:0]    rule_index;
  logic [lrps_pkg::SYM_W-1:0]     rule_lhs;
  logic [lrps_pkg::LEN_W-1:0]     rule_length;

  modport source (
    output valid, operation, lexer_status, token_id, table_row, table_symbol,
           entry_kind, entry_value, rule_index, rule_lhs, rule_length,
    input  ready
  );

  modport sink (
    input  valid, operation, lexer_status, token_id, table_row, table_symbol,
           entry_kind, entry_value, rule_index, rule_lhs, rule_length,
    output ready
  );
endinterface

// ----- hdl/lrps_result_if.sv -----
interface lrps_result_if;
  logic                            valid;
  logic                            ready;
  logic [lrps_pkg::STATUS_W-1:0]   status;
  logic [lrps_pkg::ACT_W-1:0]      action_taken;
  logic                            consume_token;
  logic [lrps_pkg::STATE_W-1:0]    pushed_state;
  logic [lrps_pkg::RULE_W-1:0]     reduced_rule;
  logic [lrps_pkg::SYM_W-1:0]      reduced_lhs;
  logic [lrps_pkg::LEN_W-1:0]      reduced_length;
  logic [lrps_pkg::DEPTH_W-1:0]    stack_depth;

  modport source (
    output valid, status, action_taken, consume_token, pushed_state,
           reduced_rule, reduced_lhs, reduced_length, stack_depth,
    input  ready
  );

  modport sink (
    input  valid, status, action_taken, consume_token, pushed_state,
           reduced_rule, reduced_lhs, reduced_length, stack_depth,
    output ready
  );
endinterface

// ----- hdl/lrps_tables.sv -----
module lrps_tables (
  input  logic               clk,
  input  logic               rst,
  input  lrps_pkg::tbl_req_t req,
  output lrps_pkg::tbl_rsp_t rsp
);

  lrps_pkg::act_entry_t  action_mem [lrps_pkg::CELLS];
  lrps_pkg::goto_entry_t goto_mem   [lrps_pkg::CELLS];
  lrps_pkg::rule_entry_t rule_mem   [lrps_pkg::NUM_RULES];

  logic [lrps_pkg::NUM_RULES-1:0] rule_vld;

  logic                        busy;
  logic [lrps_pkg::CELL_W-1:0] clr_idx;

  logic                        act_we;
  logic                        goto_we;
  logic [lrps_pkg::CELL_W-1:0] waddr;
  lrps_pkg::act_entry_t        act_wdata;
  lrps_pkg::goto_entry_t       goto_wdata;

  lrps_pkg::act_entry_t  act_q;
  lrps_pkg::goto_entry_t goto_q;
  lrps_pkg::rule_entry_t rule_q;
  logic                  rule_vld_q;

  // sweep both cell tables to invalid after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b1;
      clr_idx <= '0;
    end else if (busy) begin
      clr_idx <= clr_idx + lrps_pkg::CELL_W'(1);
      if (&clr_idx) begin
        busy <= 1'b0;
      end
    end
  end

  always_comb begin
    if (busy) begin
      act_we     = 1'b1;
      goto_we    = 1'b1;
      waddr      = clr_idx;
      act_wdata  = '0;
      goto_wdata = '0;
    end else begin
      act_we     = req.act_we;
      goto_we    = req.goto_we;
      waddr      = req.ld_cell;
      act_wdata  = req.ld_act;
      goto_wdata = req.ld_goto;
    end
  end

  always_ff @(posedge clk) begin
    if (act_we) begin
      action_mem[waddr] <= act_wdata;
    end
    if (req.act_re) begin
      act_q <= action_mem[req.act_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (goto_we) begin
      goto_mem[waddr] <= goto_wdata;
    end
    if (req.goto_re) begin
      goto_q <= goto_mem[req.goto_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (req.rule_we) begin
      rule_mem[req.ld_rule_idx] <= req.ld_rule;
    end
    if (req.rule_re) begin
      rule_q     <= rule_mem[req.rule_raddr];
      rule_vld_q <= rule_vld[req.rule_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rule_vld <= '0;
    end else if (req.rule_we) begin
      rule_vld[req.ld_rule_idx] <= 1'b1;
    end
  end

  assign rsp.busy     = busy;
  assign rsp.act      = act_q;
  assign rsp.goto_e   = goto_q;
  assign rsp.rule     = rule_q;
  assign rsp.rule_vld = rule_vld_q;

endmodule

// ----- hdl/lr_parse_step.sv -----
// Channel  | Role    | Handshake     | Carries
// ---------+---------+---------------+---------------------------------------------
// item     | sink    | valid/ready   | parse step or action/goto/rule load request
// result   | source  | valid/ready   | status, move taken, pushed state, rule info
// apb      | slave   | psel/penable  | start_state at byte address 0
//
// Loads and lexer errors finish from the FIN phase; shift, accept and action
// misses finish on the action read; a reduce chains action, rule, stack (only
// when it pops states) and goto reads. A new request is taken in the cycle the
// previous one finishes. After reset the action and goto tables are swept invalid
// with item.ready low; configuration writes are taken throughout.
// A result waits in the output register while result.ready is low; hold the step.
module lr_parse_step (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lrps_pkg::PADDR_W-1:0] paddr,
  input  logic [lrps_pkg::PDATA_W-1:0] pwdata,
  output logic [lrps_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  lrps_item_if.sink                    item,
  lrps_result_if.source                result
);

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_FIN  = 3'd1;
  localparam logic [2:0] PH_ACT  = 3'd2;
  localparam logic [2:0] PH_RULE = 3'd3;
  localparam logic [2:0] PH_STK  = 3'd4;
  localparam logic [2:0] PH_GOTO = 3'd5;

  logic [2:0] phase, phase_next;

  logic [lrps_pkg::DEPTH_W-1:0] sp, sp_next;
  logic [lrps_pkg::STATE_W-1:0] top, top_next;
  logic [lrps_pkg::RULE_W-1:0]  rule_r, rule_r_next;
  logic [lrps_pkg::SYM_W-1:0]   lhs_r, lhs_r_next;
  logic [lrps_pkg::LEN_W-1:0]   len_r, len_r_next;
  logic                         fin_load, fin_load_next;
  logic [lrps_pkg::STATE_W-1:0] start_state;

  logic                         out_valid;
  lrps_pkg::res_t               out_data;
  lrps_pkg::res_t               res;
  logic                         res_we;
  logic                         done;
  logic                         stall;
  logic                         in_ready;
  logic                         accept;
  logic [lrps_pkg::SYM_W-1:0]   tok;

  logic [lrps_pkg::STATE_W-1:0] stack_mem [lrps_pkg::STACK_DEPTH];
  logic                         stk_we;
  logic [lrps_pkg::STK_AW-1:0]  stk_waddr;
  logic [lrps_pkg::STATE_W-1:0] stk_wdata;
  logic                         stk_re;
  logic [lrps_pkg::STK_AW-1:0]  stk_raddr;
  logic [lrps_pkg::STATE_W-1:0] stk_q;

  lrps_pkg::tbl_req_t tbl_req;
  lrps_pkg::tbl_rsp_t tbl_rsp;

  logic cfg_we;

  function automatic lrps_pkg::res_t fail_res();
    lrps_pkg::res_t r;
    r              = '0;
    r.status       = lrps_pkg::ST_ERROR;
    r.action_taken = lrps_pkg::ACT_NONE;
    return r;
  endfunction

  function automatic lrps_pkg::res_t load_res();
    lrps_pkg::res_t r;
    r              = '0;
    r.status       = lrps_pkg::ST_OK;
    r.action_taken = lrps_pkg::ACT_NONE;
    return r;
  endfunction

  lrps_tables u_tables (
    .clk (clk),
    .rst (rst),
    .req (tbl_req),
    .rsp (tbl_rsp)
  );

  always_comb begin
    phase_next    = phase;
    sp_next       = sp;
    top_next      = top;
    rule_r_next   = rule_r;
    lhs_r_next    = lhs_r;
    len_r_next    = len_r;
    fin_load_next = fin_load;
    stk_we        = 1'b0;
    stk_waddr     = '0;
    stk_wdata     = '0;
    stk_re        = 1'b0;
    stk_raddr     = '0;
    tbl_req       = '0;
    res           = '0;
    done          = 1'b0;
    tok           = '0;

    stall = out_valid && !result.ready;

    if (!stall) begin
      unique case (phase)
        PH_IDLE: begin
        end
        PH_FIN: begin
          done = 1'b1;
          res  = fin_load ? load_res() : fail_res();
        end
        PH_ACT: begin
          if (!tbl_rsp.act.vld) begin
            done = 1'b1;
            res  = fail_res();
          end else begin
            unique case (tbl_rsp.act.kind)
              lrps_pkg::KIND_SHIFT: begin
                done = 1'b1;
                if (sp >= lrps_pkg::DEPTH_W'(lrps_pkg::STACK_DEPTH)) begin
                  res = fail_res();
                end else begin
                  stk_we             = 1'b1;
                  stk_waddr          = sp[lrps_pkg::STK_AW-1:0];
                  stk_wdata          = tbl_rsp.act.val;
                  sp_next            = sp + lrps_pkg::DEPTH_W'(1);
                  top_next           = tbl_rsp.act.val;
                  res.status         = lrps_pkg::ST_OK;
                  res.action_taken   = lrps_pkg::ACT_SHIFT;
                  res.consume_token  = 1'b1;
                  res.pushed_state   = tbl_rsp.act.val;
                end
              end
              lrps_pkg::KIND_ACCEPT: begin
                done             = 1'b1;
                res.status       = lrps_pkg::ST_FINISH;
                res.action_taken = lrps_pkg::ACT_ACCEPT;
              end
              lrps_pkg::KIND_REDUCE: begin
                if (int'(tbl_rsp.act.val) >= lrps_pkg::NUM_RULES) begin
                  done = 1'b1;
                  res  = fail_res();
                end else begin
                  tbl_req.rule_re    = 1'b1;
                  tbl_req.rule_raddr = lrps_pkg::RULE_AW'(tbl_rsp.act.val);
                  rule_r_next        = tbl_rsp.act.val;
                  phase_next         = PH_RULE;
                end
              end
              default: begin
                done = 1'b1;
                res  = fail_res();
              end
            endcase
          end
        end
        PH_RULE: begin
          if (!tbl_rsp.rule_vld ||
              lrps_pkg::DEPTH_W'(tbl_rsp.rule.len) >= sp) begin
            done = 1'b1;
            res  = fail_res();
          end else begin
            // pop now; the states stay popped even if the goto misses
            sp_next    = sp - lrps_pkg::DEPTH_W'(tbl_rsp.rule.len);
            lhs_r_next = tbl_rsp.rule.lhs;
            len_r_next = tbl_rsp.rule.len;
            if (tbl_rsp.rule.len == '0) begin
              if (int'(top) >= lrps_pkg::NUM_STATES ||
                  int'(tbl_rsp.rule.lhs) >= lrps_pkg::NUM_SYMBOLS) begin
                done = 1'b1;
                res  = fail_res();
              end else begin
                tbl_req.goto_re    = 1'b1;
                tbl_req.goto_raddr = lrps_pkg::cell_addr(top, tbl_rsp.rule.lhs);
                phase_next         = PH_GOTO;
              end
            end else begin
              stk_re     = 1'b1;
              stk_raddr  = lrps_pkg::STK_AW'(sp - lrps_pkg::DEPTH_W'(tbl_rsp.rule.len)
                                             - lrps_pkg::DEPTH_W'(1));
              phase_next = PH_STK;
            end
          end
        end
        PH_STK: begin
          top_next = stk_q;
          if (int'(stk_q) >= lrps_pkg::NUM_STATES ||
              int'(lhs_r) >= lrps_pkg::NUM_SYMBOLS) begin
            done = 1'b1;
            res  = fail_res();
          end else begin
            tbl_req.goto_re    = 1'b1;
            tbl_req.goto_raddr = lrps_pkg::cell_addr(stk_q, lhs_r);
            phase_next         = PH_GOTO;
          end
        end
        PH_GOTO: begin
          done = 1'b1;
          if (!tbl_rsp.goto_e.vld ||
              sp >= lrps_pkg::DEPTH_W'(lrps_pkg::STACK_DEPTH)) begin
            res = fail_res();
          end else begin
            stk_we             = 1'b1;
            stk_waddr          = sp[lrps_pkg::STK_AW-1:0];
            stk_wdata          = tbl_rsp.goto_e.val;
            sp_next            = sp + lrps_pkg::DEPTH_W'(1);
            top_next           = tbl_rsp.goto_e.val;
            res.status         = lrps_pkg::ST_OK;
            res.action_taken   = lrps_pkg::ACT_REDUCE;
            res.pushed_state   = tbl_rsp.goto_e.val;
            res.reduced_rule   = rule_r;
            res.reduced_lhs    = lhs_r;
            res.reduced_length = len_r;
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end

    res.stack_depth = sp_next;
    res_we          = done;
    if (done) begin
      phase_next = PH_IDLE;
    end

    in_ready = !tbl_rsp.busy && !stall && (phase == PH_IDLE || done);
    accept   = item.valid && in_ready;

    // new request; stack view is the one left by the step finishing now
    if (accept) begin
      phase_next    = PH_FIN;
      fin_load_next = 1'b1;
      unique case (item.operation)
        lrps_pkg::OP_PARSE: begin
          fin_load_next = 1'b0;
          if (item.lexer_status == lrps_pkg::LEX_OK ||
              item.lexer_status == lrps_pkg::LEX_END) begin
            tok = (item.lexer_status == lrps_pkg::LEX_END) ? lrps_pkg::END_TOKEN
                                                           : item.token_id;
            if (sp_next == '0) begin
              sp_next   = lrps_pkg::DEPTH_W'(1);
              top_next  = start_state;
              stk_we    = 1'b1;
              stk_waddr = '0;
              stk_wdata = start_state;
            end
            if (int'(top_next) < lrps_pkg::NUM_STATES &&
                int'(tok) < lrps_pkg::NUM_SYMBOLS) begin
              tbl_req.act_re    = 1'b1;
              tbl_req.act_raddr = lrps_pkg::cell_addr(top_next, tok);
              phase_next        = PH_ACT;
            end
          end
        end
        lrps_pkg::OP_LOAD_ACT: begin
          if (int'(item.table_row) < lrps_pkg::NUM_STATES &&
              int'(item.table_symbol) < lrps_pkg::NUM_SYMBOLS) begin
            tbl_req.act_we      = 1'b1;
            tbl_req.ld_cell     = lrps_pkg::cell_addr(item.table_row, item.table_symbol);
            tbl_req.ld_act.vld  = 1'b1;
            tbl_req.ld_act.kind = item.entry_kind;
            tbl_req.ld_act.val  = item.entry_value;
          end
        end
        lrps_pkg::OP_LOAD_GOTO: begin
          if (int'(item.table_row) < lrps_pkg::NUM_STATES &&
              int'(item.table_symbol) < lrps_pkg::NUM_SYMBOLS) begin
            tbl_req.goto_we     = 1'b1;
            tbl_req.ld_cell     = lrps_pkg::cell_addr(item.table_row, item.table_symbol);
            tbl_req.ld_goto.vld = 1'b1;
            tbl_req.ld_goto.val = item.entry_value;
          end
        end
        lrps_pkg::OP_LOAD_RULE: begin
          if (int'(item.rule_index) < lrps_pkg::NUM_RULES &&
              int'(item.rule_length) <= lrps_pkg::MAX_RHS) begin
            tbl_req.rule_we      = 1'b1;
            tbl_req.ld_rule_idx  = lrps_pkg::RULE_AW'(item.rule_index);
            tbl_req.ld_rule.lhs  = item.rule_lhs;
            tbl_req.ld_rule.len  = item.rule_length;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stack_mem[stk_waddr] <= stk_wdata;
    end
    if (stk_re) begin
      stk_q <= stack_mem[stk_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      sp          <= '0;
      out_valid   <= 1'b0;
      start_state <= '0;
    end else begin
      phase <= phase_next;
      sp    <= sp_next;
      if (res_we) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        start_state <= pwdata[lrps_pkg::STATE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    top      <= top_next;
    rule_r   <= rule_r_next;
    lhs_r    <= lhs_r_next;
    len_r    <= len_r_next;
    fin_load <= fin_load_next;
    if (res_we) begin
      out_data <= res;
    end
  end

  assign cfg_we = psel && penable && pwrite &&
                  (paddr[lrps_pkg::PADDR_W-1:2] == lrps_pkg::REG_START_STATE);
  assign pready = 1'b1;
  assign prdata = (paddr[lrps_pkg::PADDR_W-1:2] == lrps_pkg::REG_START_STATE)
                  ? lrps_pkg::PDATA_W'(start_state) : '0;

  assign item.ready = in_ready;

  assign result.valid          = out_valid;
  assign result.status         = out_data.status;
  assign result.action_taken   = out_data.action_taken;
  assign result.consume_token  = out_data.consume_token;
  assign result.pushed_state   = out_data.pushed_state;
  assign result.reduced_rule   = out_data.reduced_rule;
  assign result.reduced_lhs    = out_data.reduced_lhs;
  assign result.reduced_length = out_data.reduced_length;
  assign result.stack_depth    = out_data.stack_depth;

  a_sp_bound: assert property (@(posedge clk) disable iff (rst)
    sp <= lrps_pkg::DEPTH_W'(lrps_pkg::STACK_DEPTH))
    else $error("state stack pointer beyond stack depth");

  a_clear_idle: assert property (@(posedge clk) disable iff (rst)
    tbl_rsp.busy |-> phase == PH_IDLE)
    else $error("sequencer active during table sweep");

  a_push_top: assert property (@(posedge clk) disable iff (rst)
    res_we && (res.action_taken == lrps_pkg::ACT_SHIFT ||
               res.action_taken == lrps_pkg::ACT_REDUCE)
    |=> sp != '0 && top == out_data.pushed_state)
    else $error("cached stack top differs from pushed state");

endmodule

// ----- sim/lr_parse_step_tb.sv -----
module lr_parse_step_tb;
  import lrps_pkg::*;

  localparam logic [LEX_W-1:0]  LEX_ERROR  = 2'd2;
  localparam logic [LEX_W-1:0]  LEX_UNDEF  = 2'd3;
  localparam logic [KIND_W-1:0] KIND_ERROR = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]    operation;
    logic [LEX_W-1:0]   lexer_status;
    logic [SYM_W-1:0]   token_id;
    logic [STATE_W-1:0] table_row;
    logic [SYM_W-1:0]   table_symbol;
    logic [KIND_W-1:0]  entry_kind;
    logic [STATE_W-1:0] entry_value;
    logic [RULE_W-1:0]  rule_index;
    logic [SYM_W-1:0]   rule_lhs;
    logic [LEN_W-1:0]   rule_length;
  } parse_req_t;

  class move_scoreboard;
    act_entry_t         action_cells[CELLS];
    goto_entry_t        goto_cells[CELLS];
    rule_entry_t        rules[NUM_RULES];
    bit                 rule_loaded[NUM_RULES];
    logic [STATE_W-1:0] states[STACK_DEPTH];
    int                 depth;
    logic [STATE_W-1:0] start_state;
    res_t               pending_moves[$];
    int                 errors;

    function new();
      foreach (action_cells[i]) begin
        action_cells[i] = '0;
        goto_cells[i] = '0;
      end
      depth = 0;
      start_state = '0;
      errors = 0;
    endfunction

    function res_t error_move();
      res_t r;
      r = '0;
      r.status = ST_ERROR;
      r.action_taken = ACT_NONE;
      r.stack_depth = DEPTH_W'(depth);
      return r;
    endfunction

    function res_t predict_move(parse_req_t q);
      res_t               r;
      act_entry_t         a;
      goto_entry_t        g;
      rule_entry_t        ru;
      logic [SYM_W-1:0]   tok;
      logic [STATE_W-1:0] cur;
      int                 slot;
      r = '0;
      r.status = ST_OK;
      r.action_taken = ACT_NONE;
      if (q.operation != OP_PARSE) begin
        slot = int'(q.table_row) * NUM_SYMBOLS + int'(q.table_symbol);
        case (q.operation)
          OP_LOAD_ACT: begin
            action_cells[slot] = '{vld: 1'b1, kind: q.entry_kind, val: q.entry_value};
          end
          OP_LOAD_GOTO: begin
            goto_cells[slot] = '{vld: 1'b1, val: q.entry_value};
          end
          default: begin
            if (int'(q.rule_length) <= MAX_RHS) begin
              rules[q.rule_index] = '{lhs: q.rule_lhs, len: q.rule_length};
              rule_loaded[q.rule_index] = 1'b1;
            end
          end
        endcase
        r.stack_depth = DEPTH_W'(depth);
        return r;
      end

      // a lexer fault leaves the stack alone, not even seeded
      if (q.lexer_status != LEX_OK && q.lexer_status != LEX_END) return error_move();
      tok = (q.lexer_status == LEX_END) ? END_TOKEN : q.token_id;
      if (depth == 0) begin
        states[0] = start_state;
        depth = 1;
      end
      cur = states[depth-1];
      a = action_cells[int'(cur) * NUM_SYMBOLS + int'(tok)];
      if (!a.vld) return error_move();
      case (a.kind)
        KIND_SHIFT: begin
          if (depth >= STACK_DEPTH) return error_move();
          states[depth] = a.val;
          depth++;
          r.action_taken = ACT_SHIFT;
          r.consume_token = 1'b1;
          r.pushed_state = a.val;
        end
        KIND_ACCEPT: begin
          r.status = ST_FINISH;
          r.action_taken = ACT_ACCEPT;
        end
        KIND_REDUCE: begin
          if (!rule_loaded[a.val]) return error_move();
          ru = rules[a.val];
          if (int'(ru.len) >= depth) return error_move();
          // popped states stay popped even when the goto misses
          depth -= int'(ru.len);
          g = goto_cells[int'(states[depth-1]) * NUM_SYMBOLS + int'(ru.lhs)];
          if (!g.vld || depth >= STACK_DEPTH) return error_move();
          states[depth] = g.val;
          depth++;
          r.action_taken = ACT_REDUCE;
          r.pushed_state = g.val;
          r.reduced_rule = a.val;
          r.reduced_lhs = ru.lhs;
          r.reduced_length = ru.len;
        end
        default: return error_move();
      endcase
      r.stack_depth = DEPTH_W'(depth);
      return r;
    endfunction

    function void note(parse_req_t q);
      pending_moves = {pending_moves, predict_move(q)};
    endfunction

    function void compare(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check(res_t got);
      res_t want;
      if (pending_moves.size() == 0) begin
        $display("%0t: result with no request pending, actual %h", $time, got);
        errors++;
        return;
      end
      want = pending_moves.pop_front();
      compare("status", want.status, got.status);
      compare("action_taken", want.action_taken, got.action_taken);
      compare("consume_token", want.consume_token, got.consume_token);
      compare("pushed_state", want.pushed_state, got.pushed_state);
      compare("reduced_rule", want.reduced_rule, got.reduced_rule);
      compare("reduced_lhs", want.reduced_lhs, got.reduced_lhs);
      compare("reduced_length", want.reduced_length, got.reduced_length);
      compare("stack_depth", want.stack_depth, got.stack_depth);
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  lrps_item_if   item_ch();
  lrps_result_if res_ch();

  lr_parse_step dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .item    (item_ch),
    .result  (res_ch)
  );

  move_scoreboard     sb;
  int                 hold_len = 0;
  bit                 steady = 1'b0;
  bit                 burst = 1'b0;
  logic [STATE_W-1:0] state_pool[8];
  logic [SYM_W-1:0]   term_pool[7];
  logic [SYM_W-1:0]   nt_pool[4];
  logic [RULE_W-1:0]  rule_pool[8];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #4_000_000;
    $display("** lr_parse_step: FAILED **");
    $finish;
  end

  function automatic parse_req_t parse_req(logic [LEX_W-1:0] lex, logic [SYM_W-1:0] tok);
    parse_req_t q;
    q = '0;
    q.operation = OP_PARSE;
    q.lexer_status = lex;
    q.token_id = tok;
    return q;
  endfunction

  function automatic parse_req_t action_req(logic [STATE_W-1:0] row, logic [SYM_W-1:0] sym,
                                            logic [KIND_W-1:0] kind, logic [STATE_W-1:0] val);
    parse_req_t q;
    q = '0;
    q.operation = OP_LOAD_ACT;
    q.table_row = row;
    q.table_symbol = sym;
    q.entry_kind = kind;
    q.entry_value = val;
    return q;
  endfunction

  function automatic parse_req_t goto_req(logic [STATE_W-1:0] row, logic [SYM_W-1:0] sym,
                                          logic [STATE_W-1:0] val);
    parse_req_t q;
    q = '0;
    q.operation = OP_LOAD_GOTO;
    q.table_row = row;
    q.table_symbol = sym;
    q.entry_value = val;
    return q;
  endfunction

  function automatic parse_req_t rule_req(logic [RULE_W-1:0] idx, logic [SYM_W-1:0] lhs,
                                          logic [LEN_W-1:0] len);
    parse_req_t q;
    q = '0;
    q.operation = OP_LOAD_RULE;
    q.rule_index = idx;
    q.rule_lhs = lhs;
    q.rule_length = len;
    return q;
  endfunction

  task automatic present(parse_req_t q);
    item_ch.operation    <= q.operation;
    item_ch.lexer_status <= q.lexer_status;
    item_ch.token_id     <= q.token_id;
    item_ch.table_row    <= q.table_row;
    item_ch.table_symbol <= q.table_symbol;
    item_ch.entry_kind   <= q.entry_kind;
    item_ch.entry_value  <= q.entry_value;
    item_ch.rule_index   <= q.rule_index;
    item_ch.rule_lhs     <= q.rule_lhs;
    item_ch.rule_length  <= q.rule_length;
  endtask

  task automatic send(parse_req_t q);
    int gap;
    gap = (steady || burst) ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid <= 1'b1;
    present(q);
    do @(posedge clk); while (!item_ch.ready);
  endtask

  // hold off new requests until every result is back
  task automatic drain();
    item_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending_moves.size() != 0);
  endtask

  task automatic set_start(logic [STATE_W-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_START_STATE, 2'b00};
    pwdata  <= PDATA_W'(v);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.start_state = v;
    @(posedge clk);
  endtask

  task automatic load_action(int si, int ti);
    int                 pick;
    logic [KIND_W-1:0]  kind;
    logic [STATE_W-1:0] val;
    pick = $urandom_range(0, 99);
    if (pick < 42) begin
      kind = KIND_SHIFT;
      val = state_pool[$urandom_range(0, 7)];
    end else if (pick < 82) begin
      kind = KIND_REDUCE;
      val = (pick < 78) ? rule_pool[$urandom_range(0, 7)] : STATE_W'($urandom_range(0, 255));
    end else if (pick < 90) begin
      kind = KIND_ACCEPT;
      val = STATE_W'($urandom_range(0, 255));
    end else begin
      kind = KIND_ERROR;
      val = STATE_W'($urandom_range(0, 255));
    end
    send(action_req(state_pool[si], term_pool[ti], kind, val));
  endtask

  task automatic load_goto(int si, int ni);
    send(goto_req(state_pool[si], nt_pool[ni], state_pool[$urandom_range(0, 7)]));
  endtask

  task automatic load_rule(int ri);
    logic [SYM_W-1:0] lhs;
    logic [LEN_W-1:0] len;
    lhs = ($urandom_range(0, 9) != 0) ? nt_pool[$urandom_range(0, 3)]
                                      : SYM_W'($urandom_range(0, 63));
    // keep most rules short so the depth wanders both ways
    len = ($urandom_range(0, 19) < 17) ? LEN_W'($urandom_range(0, 4))
                                       : LEN_W'($urandom_range(0, 15));
    send(rule_req(rule_pool[ri], lhs, len));
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (res_ch.valid && res_ch.ready)
        sb.check({res_ch.status, res_ch.action_taken, res_ch.consume_token,
                  res_ch.pushed_state, res_ch.reduced_rule, res_ch.reduced_lhs,
                  res_ch.reduced_length, res_ch.stack_depth});
      if (item_ch.valid && item_ch.ready)
        sb.note({item_ch.operation, item_ch.lexer_status, item_ch.token_id,
                 item_ch.table_row, item_ch.table_symbol, item_ch.entry_kind,
                 item_ch.entry_value, item_ch.rule_index, item_ch.rule_lhs,
                 item_ch.rule_length});
    end
  end

  initial begin : result_sink
    int wait_cycles;
    res_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_len > 0) begin
        res_ch.ready <= 1'b0;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
      end
      wait_cycles = steady ? 0 : $urandom_range(0, 13);
      if (wait_cycles > 0) begin
        res_ch.ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!res_ch.valid);
    end
  end

  initial begin : stimulus
    int         base;
    int         pick;
    parse_req_t noise;
    sb = new();
    rst     <= 1'b1;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    item_ch.valid <= 1'b0;
    present('0);
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // table sweep runs after reset; the register port stays open
    set_start(8'd0);
    set_start(8'd255);

    send(parse_req(LEX_ERROR, 6'd0));
    send(parse_req(LEX_UNDEF, 6'd63));
    // empty stack gets seeded even though the lookup misses
    send(parse_req(LEX_OK, 6'd5));
    send(action_req(8'd255, 6'd63, KIND_SHIFT, 8'd0));
    send(parse_req(LEX_END, 6'd17));
    send(rule_req(8'd255, 6'd63, 4'd15));
    send(action_req(8'd0, 6'd1, KIND_REDUCE, 8'd255));
    send(parse_req(LEX_OK, 6'd1));
    send(rule_req(8'd7, 6'd2, 4'd1));
    send(action_req(8'd0, 6'd2, KIND_REDUCE, 8'd7));
    send(parse_req(LEX_OK, 6'd2));
    send(goto_req(8'd255, 6'd2, 8'd128));
    send(parse_req(LEX_END, 6'd0));
    send(parse_req(LEX_OK, 6'd2));
    send(action_req(8'd128, 6'd3, KIND_REDUCE, 8'd9));
    send(parse_req(LEX_OK, 6'd3));
    send(action_req(8'd128, 6'd4, KIND_ERROR, 8'd0));
    send(parse_req(LEX_OK, 6'd4));
    send(action_req(8'd128, 6'd63, KIND_ACCEPT, 8'd0));
    send(parse_req(LEX_END, 6'd9));
    send(parse_req(LEX_OK, 6'd63));
    send(goto_req(8'd0, 6'd63, 8'd255));
    send(rule_req(8'd0, 6'd0, 4'd0));
    send(action_req(8'd128, 6'd5, KIND_REDUCE, 8'd0));
    send(goto_req(8'd128, 6'd0, 8'd0));
    send(parse_req(LEX_OK, 6'd5));
    drain();

    // grammar universe; keep the states left on the stack so far
    state_pool[0] = 8'd0;
    state_pool[1] = 8'd128;
    state_pool[2] = 8'd255;
    for (int i = 3; i < 8; i++) state_pool[i] = STATE_W'($urandom_range(0, 255));
    base = $urandom_range(0, 56);
    for (int i = 0; i < 6; i++) term_pool[i] = SYM_W'(base + i);
    term_pool[6] = END_TOKEN;
    base = $urandom_range(0, 60);
    for (int i = 0; i < 4; i++) nt_pool[i] = SYM_W'(base + i);
    base = $urandom_range(0, 248);
    for (int i = 0; i < 8; i++) rule_pool[i] = RULE_W'(base + i);

    set_start(STATE_W'($urandom_range(0, 255)));
    for (int s = 0; s < 8; s++) begin
      for (int t = 0; t < 7; t++) load_action(s, t);
      for (int n = 0; n < 4; n++) load_goto(s, n);
    end
    for (int r = 0; r < 8; r++) load_rule(r);

    // fill the stack to the top, then try shift and empty-rule reduce on it
    drain();
    for (int s = 0; s < 8; s++)
      send(action_req(state_pool[s], term_pool[0], KIND_SHIFT, state_pool[$urandom_range(0, 7)]));
    send(rule_req(rule_pool[0], nt_pool[0], 4'd0));
    for (int s = 0; s < 8; s++)
      send(action_req(state_pool[s], term_pool[1], KIND_REDUCE, rule_pool[0]));
    repeat (70) send(parse_req(LEX_OK, term_pool[0]));
    repeat (4) send(parse_req(LEX_OK, term_pool[1]));
    for (int s = 0; s < 8; s++) begin
      load_action(s, 0);
      load_action(s, 1);
    end
    load_rule(0);

    for (int p = 0; p < 6; p++) begin
      drain();
      set_start(p == 0 ? 8'd0 : (p == 3 ? 8'd255 : STATE_W'($urandom_range(0, 255))));
      if (p == 1) begin
        // stall the result side while requests keep coming
        hold_len = 400;
        burst = 1'b1;
      end
      steady = (p == 2);
      repeat (24) begin
        pick = $urandom_range(0, 99);
        if (pick < 60)
          load_action($urandom_range(0, 7), $urandom_range(0, 6));
        else if (pick < 85)
          load_goto($urandom_range(0, 7), $urandom_range(0, 3));
        else
          load_rule($urandom_range(0, 7));
      end
      for (int n = 0; n < 180; n++) begin
        if (n == 60) burst = 1'b0;
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
          noise.operation    = OP_W'($urandom_range(0, 3));
          noise.lexer_status = LEX_W'($urandom_range(0, 3));
          noise.token_id     = SYM_W'($urandom_range(0, 63));
          noise.table_row    = STATE_W'($urandom_range(0, 255));
          noise.table_symbol = SYM_W'($urandom_range(0, 63));
          noise.entry_kind   = KIND_W'($urandom_range(0, 3));
          noise.entry_value  = STATE_W'($urandom_range(0, 255));
          noise.rule_index   = RULE_W'($urandom_range(0, 255));
          noise.rule_lhs     = SYM_W'($urandom_range(0, 63));
          noise.rule_length  = LEN_W'($urandom_range(0, 15));
          send(noise);
        end else if (pick < 82) begin
          send(parse_req(LEX_OK, term_pool[$urandom_range(0, 6)]));
        end else if (pick < 92) begin
          send(parse_req(LEX_END, SYM_W'($urandom_range(0, 63))));
        end else if (pick < 96) begin
          send(parse_req(LEX_ERROR, SYM_W'($urandom_range(0, 63))));
        end else if (pick < 98) begin
          send(parse_req(LEX_UNDEF, SYM_W'($urandom_range(0, 63))));
        end else begin
          send(parse_req(LEX_OK, SYM_W'($urandom_range(0, 63))));
        end
      end
    end
    steady = 1'b0;

    drain();
    repeat (10) @(posedge clk);
    if (sb.errors == 0)
      $display("** lr_parse_step: PASSED **");
    else
      $display("** lr_parse_step: FAILED **");
    $finish;
  end

endmodule

// ----- files.f -----
hdl/lrps_pkg.sv
hdl/lrps_item_if.sv
hdl/lrps_result_if.sv
hdl/lrps_tables.sv
hdl/lr_parse_step.sv
sim/lr_parse_step_tb.sv
